// ===== src/dhcpop_pkg.sv =====
// ----------------------------------------------------------------------------
// dhcpop_pkg
// Types and constants shared by the DHCP reply option parser modules.
// ----------------------------------------------------------------------------
package dhcpop_pkg;

  // Magic cookie and option codes
  localparam logic [31:0] COOKIE_VALUE = 32'h6382_5363;
  localparam logic [7:0]  COOKIE_LEN   = 8'd4;
  localparam logic [7:0]  OPT_PAD      = 8'd0;
  localparam logic [7:0]  OPT_END      = 8'd255;
  localparam logic [7:0]  OPT_MSG_TYPE = 8'd53;
  localparam logic [7:0]  OPT_ROUTER   = 8'd3;
  localparam logic [7:0]  OPT_DNS      = 8'd6;
  localparam logic [7:0]  MSG_OFFER    = 8'd2;
  localparam logic [7:0]  MSG_ACK      = 8'd5;
  localparam logic [7:0]  MSG_NAK      = 8'd6;
  localparam logic [7:0]  ADDR_LEN     = 8'd4;

  // Result status codes
  localparam logic [1:0] ST_OK         = 2'd0;
  localparam logic [1:0] ST_BAD_COOKIE = 2'd1;
  localparam logic [1:0] ST_WRONG_TYPE = 2'd2;
  localparam logic [1:0] ST_TRUNCATED  = 2'd3;

  // Parser phase
  typedef enum logic [2:0] {
    PH_IDLE,
    PH_COOKIE,
    PH_TYPE,
    PH_LEN,
    PH_VALUE,
    PH_DONE
  } phase_e;

  // One input beat
  typedef struct packed {
    logic [7:0] data;
    logic       first;
    logic       last;
  } item_t;

  // One result beat
  typedef struct packed {
    logic [1:0]  status;
    logic        gw_found;
    logic [31:0] gw_addr;
    logic        dns_found;
    logic [31:0] dns_addr;
  } result_t;

endpackage

// ===== src/dhcp_reply_option_parser.sv =====
// ----------------------------------------------------------------------------
// dhcp_reply_option_parser
// Path: a byte is registered at input, parsed as it advances, result beat registered.
// Throughput: one byte per cycle; a stalled result holds input.
// Reset: asynchronous, active low; parser idle, stores cleared, awaited reply offer.
// ----------------------------------------------------------------------------
module dhcp_reply_option_parser import dhcpop_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  // input channel
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  data_byte_i,
  input  logic        first_byte_i,
  input  logic        last_byte_i,
  // result channel
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [1:0]  status_o,
  output logic        gateway_found_o,
  output logic [31:0] router_addr_o,
  output logic        dns_found_o,
  output logic [31:0] dns_addr_o,
  // configuration channel
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic        cfg_data_i
);

  item_t   in_q, in_d;
  logic    in_valid_q, in_valid_d;
  result_t out_q, out_d;
  logic    out_valid_q, out_valid_d;
  logic    awaited_q, awaited_d;
  logic    advance;
  logic    res_valid;
  result_t res;

  // Config register, always ready
  assign cfg_ready_o = 1'b1;
  assign awaited_d   = cfg_valid_i ? cfg_data_i : awaited_q;

  // Input stage moves on when the result register can take a beat
  assign advance    = in_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o = in_valid_q && !advance;

  always_comb begin
    in_valid_d = in_stall_o ? in_valid_q : in_valid_i;
    in_d       = in_q;
    if (in_valid_i && !in_stall_o) begin
      in_d.data  = data_byte_i;
      in_d.first = first_byte_i;
      in_d.last  = last_byte_i;
    end
  end

  dhcpop_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .step_i      (advance),
    .item_i      (in_q),
    .awaited_i   (awaited_q),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  // Result register
  always_comb begin
    out_d       = res_valid ? res : out_q;
    out_valid_d = res_valid ? 1'b1 : (out_valid_q && out_stall_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      awaited_q   <= 1'b0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
      awaited_q   <= awaited_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    in_q  <= in_d;
    out_q <= out_d;
  end

  assign out_valid_o     = out_valid_q;
  assign status_o        = out_q.status;
  assign gateway_found_o = out_q.gw_found;
  assign router_addr_o   = out_q.gw_addr;
  assign dns_found_o     = out_q.dns_found;
  assign dns_addr_o      = out_q.dns_addr;

endmodule

// ===== src/dhcpop_core.sv =====
// ----------------------------------------------------------------------------
// dhcpop_core
// Parser state and option walk; one byte per enabled cycle.
// ----------------------------------------------------------------------------
module dhcpop_core import dhcpop_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    step_i,
  input  item_t   item_i,
  input  logic    awaited_i,
  output logic    res_valid_o,
  output result_t res_o
);

  phase_e      phase_q, phase_d;
  logic [31:0] cookie_q, cookie_d;
  logic [7:0]  cnt_q, cnt_d;
  logic [7:0]  opt_q, opt_d;
  logic [31:0] addr_q, addr_d;
  logic        gw_found_q, gw_found_d;
  logic [31:0] gw_q, gw_d;
  logic        dns_found_q, dns_found_d;
  logic [31:0] dns_q, dns_d;
  logic        matched_q, matched_d;

  logic [31:0] cookie_next;
  logic [7:0]  cnt_inc;
  logic        in_packet;
  logic        bad_cookie;
  logic        end_opt;
  logic        decided;
  logic        truncated;
  logic        type_ok;

  // Shared decode of the current byte
  assign cookie_next = {cookie_q[23:0], item_i.data};
  assign cnt_inc     = cnt_q + 8'd1;
  assign in_packet   = (phase_q == PH_COOKIE) || (phase_q == PH_TYPE) ||
                       (phase_q == PH_LEN) || (phase_q == PH_VALUE);
  assign bad_cookie  = !item_i.first && (phase_q == PH_COOKIE) &&
                       (cnt_inc >= COOKIE_LEN) && (cookie_next != COOKIE_VALUE);
  assign end_opt     = !item_i.first && (phase_q == PH_TYPE) && (item_i.data == OPT_END);
  assign decided     = bad_cookie || end_opt;
  assign truncated   = (item_i.first || in_packet) && item_i.last && !decided;
  assign type_ok     = awaited_i ? ((item_i.data == MSG_ACK) || (item_i.data == MSG_NAK))
                                 : (item_i.data == MSG_OFFER);

  // Next phase
  always_comb begin
    phase_d = phase_q;
    if (step_i) begin
      if (item_i.first) begin
        phase_d = PH_COOKIE;
      end else begin
        unique case (phase_q)
          PH_COOKIE: begin
            if (cnt_inc >= COOKIE_LEN) phase_d = PH_TYPE;
          end
          PH_TYPE: begin
            if (item_i.data != OPT_PAD) phase_d = PH_LEN;
          end
          PH_LEN: begin
            phase_d = (item_i.data == 8'd0) ? PH_TYPE : PH_VALUE;
          end
          PH_VALUE: begin
            if (cnt_inc >= cookie_q[7:0]) phase_d = PH_TYPE;
          end
          default: phase_d = phase_q;
        endcase
      end
      if (decided || truncated) phase_d = PH_DONE;
    end
  end

  // Datapath and stores
  always_comb begin
    cookie_d    = cookie_q;
    cnt_d       = cnt_q;
    opt_d       = opt_q;
    addr_d      = addr_q;
    gw_found_d  = gw_found_q;
    gw_d        = gw_q;
    dns_found_d = dns_found_q;
    dns_d       = dns_q;
    matched_d   = matched_q;
    if (step_i) begin
      if (item_i.first) begin
        cookie_d    = {24'd0, item_i.data};
        cnt_d       = 8'd1;
        opt_d       = 8'd0;
        addr_d      = 32'd0;
        gw_found_d  = 1'b0;
        gw_d        = 32'd0;
        dns_found_d = 1'b0;
        dns_d       = 32'd0;
        matched_d   = 1'b0;
      end else begin
        case (phase_q)
          PH_COOKIE: begin
            cookie_d = cookie_next;
            cnt_d    = cnt_inc;
          end
          PH_TYPE: begin
            if (item_i.data != OPT_PAD && item_i.data != OPT_END) opt_d = item_i.data;
          end
          PH_LEN: begin
            if (item_i.data != 8'd0) begin
              cookie_d = {24'd0, item_i.data};
              cnt_d    = 8'd0;
              addr_d   = 32'd0;
            end
          end
          PH_VALUE: begin
            if (cnt_q == 8'd0 && opt_q == OPT_MSG_TYPE && type_ok) matched_d = 1'b1;
            if (cnt_q < ADDR_LEN) addr_d = {addr_q[23:0], item_i.data};
            cnt_d = cnt_inc;
            // option closes: keep address if long enough
            if (cnt_inc >= cookie_q[7:0] && cookie_q[7:0] >= ADDR_LEN) begin
              if (opt_q == OPT_ROUTER) begin
                gw_found_d = 1'b1;
                gw_d       = addr_d;
              end else if (opt_q == OPT_DNS) begin
                dns_found_d = 1'b1;
                dns_d       = addr_d;
              end
            end
          end
          default: ;
        endcase
      end
    end
  end

  // Result outputs
  always_comb begin
    res_valid_o     = step_i && (decided || truncated);
    res_o.gw_found  = gw_found_d;
    res_o.gw_addr   = gw_d;
    res_o.dns_found = dns_found_d;
    res_o.dns_addr  = dns_d;
    if (bad_cookie)   res_o.status = ST_BAD_COOKIE;
    else if (end_opt) res_o.status = matched_q ? ST_OK : ST_WRONG_TYPE;
    else              res_o.status = ST_TRUNCATED;
  end

  // State registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_IDLE;
      cookie_q    <= 32'd0;
      cnt_q       <= 8'd0;
      opt_q       <= 8'd0;
      addr_q      <= 32'd0;
      gw_found_q  <= 1'b0;
      gw_q        <= 32'd0;
      dns_found_q <= 1'b0;
      dns_q       <= 32'd0;
      matched_q   <= 1'b0;
    end else begin
      phase_q     <= phase_d;
      cookie_q    <= cookie_d;
      cnt_q       <= cnt_d;
      opt_q       <= opt_d;
      addr_q      <= addr_d;
      gw_found_q  <= gw_found_d;
      gw_q        <= gw_d;
      dns_found_q <= dns_found_d;
      dns_q       <= dns_d;
      matched_q   <= matched_d;
    end
  end

endmodule
